>>> rtl/differential_drive_odometry_top_defines.svh
// assertion helpers for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define DDO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int POSITION_WIDTH_DEF = 40;
  localparam int ANGLE_WIDTH_DEF    = 16;

  localparam int STEP_LENGTH_W = 24;
  localparam int HPD_W         = 16;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADING_PER_DIST = 1'b1;

  localparam logic [STEP_LENGTH_W-1:0] STEP_LENGTH_RST = 24'd65536;
  localparam logic [HPD_W-1:0]         HPD_RST         = 16'd256;

  // cordic: 20 rotations on a 32-bit angle, gain-compensated start in q4.30
  localparam int CORDIC_STEPS = 20;
  localparam int ITER_W       = 5;
  localparam int CORDIC_W     = 34;
  localparam logic [ITER_W-1:0]            ITER_LAST    = ITER_W'(CORDIC_STEPS - 1);
  localparam logic signed [CORDIC_W-1:0]   CORDIC_START = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] position_left;
    logic signed [31:0] position_right;
  } ddo_in_t;

  typedef struct packed {
    logic signed [39:0] pose_x;
    logic signed [39:0] pose_y;
    logic signed [15:0] heading;
  } ddo_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIFF,
    ST_HEAD,
    ST_INIT,
    ST_CORDIC,
    ST_ROUND,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_PUSH
  } ddo_state_t;

  typedef struct packed {
    logic              take;
    logic              scale;
    logic              diff;
    logic              head;
    logic              init;
    logic              iter;
    logic              round;
    logic              mlo;
    logic              mhi;
    logic              acc;
    logic              push;
    logic [ITER_W-1:0] step;
  } ddo_cmd_t;

  function automatic logic signed [CORDIC_W-1:0] atan_of(input logic [ITER_W-1:0] i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      5'd0:    a = 34'sh020000000;
      5'd1:    a = 34'sh012E4051E;
      5'd2:    a = 34'sh009FB385B;
      5'd3:    a = 34'sh0051111D4;
      5'd4:    a = 34'sh0028B0D43;
      5'd5:    a = 34'sh00145D7E1;
      5'd6:    a = 34'sh000A2F61E;
      5'd7:    a = 34'sh000517C55;
      5'd8:    a = 34'sh00028BE53;
      5'd9:    a = 34'sh000145F2F;
      5'd10:   a = 34'sh0000A2F98;
      5'd11:   a = 34'sh0000517CC;
      5'd12:   a = 34'sh000028BE6;
      5'd13:   a = 34'sh0000145F3;
      5'd14:   a = 34'sh00000A2FA;
      5'd15:   a = 34'sh00000517D;
      5'd16:   a = 34'sh0000028BE;
      5'd17:   a = 34'sh00000145F;
      5'd18:   a = 34'sh000000A30;
      5'd19:   a = 34'sh000000518;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/ddo_ctrl.sv
module ddo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output ddo_pkg::ddo_cmd_t cmd
);
  import ddo_pkg::*;

  ddo_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIST;
      ST_DIST:   state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_HEAD;
      ST_HEAD:   state_nxt = ST_INIT;
      ST_INIT:   state_nxt = ST_CORDIC;
      ST_CORDIC: if (iter_r == ITER_LAST) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_MLO;
      ST_MLO:    state_nxt = ST_MHI;
      ST_MHI:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_PUSH;
      ST_PUSH:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.step = iter_r;
    case (state_r)
      ST_IDLE:   cmd.take  = in_valid;
      ST_DIST:   cmd.scale = 1'b1;
      ST_DIFF:   cmd.diff  = 1'b1;
      ST_HEAD:   cmd.head  = 1'b1;
      ST_INIT:   cmd.init  = 1'b1;
      ST_CORDIC: cmd.iter  = 1'b1;
      ST_ROUND:  cmd.round = 1'b1;
      ST_MLO:    cmd.mlo   = 1'b1;
      ST_MHI:    cmd.mhi   = 1'b1;
      ST_ACC:    cmd.acc   = 1'b1;
      ST_PUSH:   cmd.push  = slot_free;
      default:   cmd       = '0;
    endcase
  end

  always_comb begin
    iter_nxt = (state_r == ST_CORDIC) ? ITER_W'(iter_r + 1'b1) : '0;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/ddo_dp.sv
module ddo_dp #(
  parameter int COUNT_WIDTH    = ddo_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = ddo_pkg::POSITION_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = ddo_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  ddo_pkg::ddo_in_t                   in_data,
  input  ddo_pkg::ddo_cmd_t                  cmd,
  output ddo_pkg::ddo_out_t                  out_data
);
  import ddo_pkg::*;

  localparam int CW      = COUNT_WIDTH;
  localparam int DW      = CW + 1;
  localparam int PROD_W  = DW + STEP_LENGTH_W + 1;
  localparam int DIST_W  = PROD_W - 8;
  localparam int PW      = POSITION_WIDTH;
  localparam int AW      = ANGLE_WIDTH;
  localparam int MW      = PW + 15;
  localparam int MEAN_W  = (DIST_W > MW) ? DIST_W : MW;
  localparam int EXT_W   = MEAN_W + 1;
  localparam int TW      = HPD_W + AW;
  localparam int LO_W    = (MW + 1) / 2;
  localparam int HI_W    = MW - LO_W;
  localparam int PLO_W   = LO_W + 17;
  localparam int PHI_W   = HI_W + 16;

  localparam logic signed [CORDIC_W:0] SAT_HI = (CORDIC_W+1)'(32767);
  localparam logic signed [CORDIC_W:0] SAT_LO = (CORDIC_W+1)'(-32767);
  localparam logic signed [CORDIC_W:0] HALF_Q = (CORDIC_W+1)'(16384);

  function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v,
                                                input logic neg);
    logic signed [CORDIC_W:0] t;
    logic signed [15:0]       r;
    t = $signed({v[CORDIC_W-1], v}) + HALF_Q;
    t = t >>> 15;
    if (t > SAT_HI) begin
      r = 16'sd32767;
    end else if (t < SAT_LO) begin
      r = -16'sd32767;
    end else begin
      r = t[15:0];
    end
    return neg ? -r : r;
  endfunction

  // configuration and architectural state
  logic [STEP_LENGTH_W-1:0] step_len_r, step_len_nxt;
  logic [HPD_W-1:0]         hpd_r, hpd_nxt;
  logic [CW-1:0]            last_left_r, last_left_nxt;
  logic [CW-1:0]            last_right_r, last_right_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [PW-1:0]            px_r, px_nxt;
  logic [PW-1:0]            py_r, py_nxt;

  // working registers
  logic signed [DW-1:0]       dl_r, dl_nxt, dr_r, dr_nxt;
  logic signed [DIST_W-1:0]   distl_r, distl_nxt, distr_r, distr_nxt;
  logic [TW-1:0]              diff_r, diff_nxt;
  logic signed [MEAN_W-1:0]   mean_r, mean_nxt;
  logic signed [CORDIC_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic                       flip_r, flip_nxt;
  logic signed [15:0]         cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [PLO_W-1:0]    plo_x_r, plo_x_nxt, plo_y_r, plo_y_nxt;
  logic signed [PHI_W-1:0]    phi_x_r, phi_x_nxt, phi_y_r, phi_y_nxt;
  ddo_out_t                   out_r, out_nxt;

  // combinational helpers
  logic [CW-1:0]              dlw, drw;
  logic signed [PROD_W-1:0]   prod_l, prod_r;
  logic signed [EXT_W-1:0]    ext_l, ext_r, sum_lr, diff_lr;
  logic [TW+HPD_W-1:0]        turn_prod;
  logic [31:0]                ang;
  logic                       ang_flip;
  logic [31:0]                ang_rot;
  logic signed [CORDIC_W-1:0] xs, ys, atan_i;
  logic [LO_W-1:0]            m_lo;
  logic signed [HI_W-1:0]     m_hi;
  logic [MW-1:0]              sum_x, sum_y;
  logic [PW+39:0]             px_wide, py_wide;
  logic [AW+15:0]             head_wide;

  assign dlw     = in_data.position_left[CW-1:0] - last_left_r;
  assign drw     = in_data.position_right[CW-1:0] - last_right_r;
  assign prod_l  = dl_r * $signed({1'b0, step_len_r});
  assign prod_r  = dr_r * $signed({1'b0, step_len_r});
  assign ext_l   = {{(EXT_W-DIST_W){distl_r[DIST_W-1]}}, distl_r};
  assign ext_r   = {{(EXT_W-DIST_W){distr_r[DIST_W-1]}}, distr_r};
  assign sum_lr  = ext_l + ext_r;
  assign diff_lr = ext_l - ext_r;
  assign turn_prod = diff_r * hpd_r;
  assign ang      = {head_r, {(32-AW){1'b0}}};
  assign ang_flip = ang[31] ^ ang[30];
  assign ang_rot  = {ang[31] ^ ang_flip, ang[30:0]};
  assign xs       = cx_r >>> cmd.step;
  assign ys       = cy_r >>> cmd.step;
  assign atan_i   = atan_of(cmd.step);
  assign m_lo     = mean_r[LO_W-1:0];
  assign m_hi     = mean_r[MW-1:LO_W];
  assign sum_x = {{(MW-PLO_W){plo_x_r[PLO_W-1]}}, plo_x_r}
               + {phi_x_r[HI_W-1:0], {LO_W{1'b0}}};
  assign sum_y = {{(MW-PLO_W){plo_y_r[PLO_W-1]}}, plo_y_r}
               + {phi_y_r[HI_W-1:0], {LO_W{1'b0}}};
  assign px_wide   = {{40{px_r[PW-1]}}, px_r};
  assign py_wide   = {{40{py_r[PW-1]}}, py_r};
  assign head_wide = {{16{head_r[AW-1]}}, head_r};

  always_comb begin
    step_len_nxt = step_len_r;
    hpd_nxt      = hpd_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_LENGTH:      step_len_nxt = cfg_wdata[STEP_LENGTH_W-1:0];
        CFG_HEADING_PER_DIST: hpd_nxt      = cfg_wdata[HPD_W-1:0];
        default:              step_len_nxt = step_len_r;
      endcase
    end
  end

  always_comb begin
    last_left_nxt  = last_left_r;
    last_right_nxt = last_right_r;
    dl_nxt         = dl_r;
    dr_nxt         = dr_r;
    if (cmd.take) begin
      last_left_nxt  = in_data.position_left[CW-1:0];
      last_right_nxt = in_data.position_right[CW-1:0];
      // left motor is mirrored: negate its wrapped delta
      dl_nxt = DW'(~{dlw[CW-1], dlw} + DW'(1));
      dr_nxt = {drw[CW-1], drw};
    end
  end

  always_comb begin
    distl_nxt = distl_r;
    distr_nxt = distr_r;
    diff_nxt  = diff_r;
    mean_nxt  = mean_r;
    head_nxt  = head_r;
    if (cmd.scale) begin
      distl_nxt = prod_l[PROD_W-1:8];
      distr_nxt = prod_r[PROD_W-1:8];
    end
    if (cmd.diff) begin
      diff_nxt = diff_lr[TW-1:0];
      mean_nxt = sum_lr[EXT_W-1:1];
    end
    if (cmd.head) begin
      head_nxt = head_r + turn_prod[TW-1:HPD_W];
    end
  end

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    flip_nxt = flip_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (cmd.init) begin
      flip_nxt = ang_flip;
      cx_nxt   = CORDIC_START;
      cy_nxt   = '0;
      cz_nxt   = {{(CORDIC_W-32){ang_rot[31]}}, ang_rot};
    end
    if (cmd.iter) begin
      if (!cz_r[CORDIC_W-1]) begin
        cx_nxt = cx_r - ys;
        cy_nxt = cy_r + xs;
        cz_nxt = cz_r - atan_i;
      end else begin
        cx_nxt = cx_r + ys;
        cy_nxt = cy_r - xs;
        cz_nxt = cz_r + atan_i;
      end
    end
    if (cmd.round) begin
      cos_nxt = to_q15(cx_r, flip_r);
      sin_nxt = to_q15(cy_r, flip_r);
    end
  end

  always_comb begin
    plo_x_nxt = plo_x_r;
    plo_y_nxt = plo_y_r;
    phi_x_nxt = phi_x_r;
    phi_y_nxt = phi_y_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    out_nxt   = out_r;
    if (cmd.mlo) begin
      plo_x_nxt = $signed({1'b0, m_lo}) * cos_r;
      plo_y_nxt = $signed({1'b0, m_lo}) * sin_r;
    end
    if (cmd.mhi) begin
      phi_x_nxt = m_hi * cos_r;
      phi_y_nxt = m_hi * sin_r;
    end
    if (cmd.acc) begin
      px_nxt = px_r + sum_x[MW-1:15];
      py_nxt = py_r + sum_y[MW-1:15];
    end
    if (cmd.push) begin
      out_nxt.pose_x  = px_wide[39:0];
      out_nxt.pose_y  = py_wide[39:0];
      out_nxt.heading = head_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r   <= STEP_LENGTH_RST;
      hpd_r        <= HPD_RST;
      last_left_r  <= '0;
      last_right_r <= '0;
      head_r       <= '0;
      px_r         <= '0;
      py_r         <= '0;
    end else begin
      step_len_r   <= step_len_nxt;
      hpd_r        <= hpd_nxt;
      last_left_r  <= last_left_nxt;
      last_right_r <= last_right_nxt;
      head_r       <= head_nxt;
      px_r         <= px_nxt;
      py_r         <= py_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r    <= dl_nxt;
    dr_r    <= dr_nxt;
    distl_r <= distl_nxt;
    distr_r <= distr_nxt;
    diff_r  <= diff_nxt;
    mean_r  <= mean_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    flip_r  <= flip_nxt;
    cos_r   <= cos_nxt;
    sin_r   <= sin_nxt;
    plo_x_r <= plo_x_nxt;
    plo_y_r <= plo_y_nxt;
    phi_x_r <= phi_x_nxt;
    phi_y_r <= phi_y_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> rtl/differential_drive_odometry_top.sv
// differential-drive odometry: each transfer on the input channel carries the absolute step
// counts of the left and right wheel motors; the block forms wrapped deltas against the
// previous transfer (left negated, as that motor is mounted mirrored), scales them by
// step_length into wheel travel in 1/256 mm, adds (left - right) times heading_per_distance
// to a binary-angle heading that wraps over a full turn, and adds the mean travel times
// cos/sin of the new heading to wrapping x/y positions; one pose transfer per input transfer.
// the 20-step cordic shares one shift-add unit; the next input can be taken in the cycle
// after the result enters the output register, and a result still waiting there holds the
// block only at that final step. configuration is written through a plain write port; the
// user must write it only while idle, as the block itself does not enforce this.
`include "differential_drive_odometry_top_defines.svh"

module differential_drive_odometry_top #(
  parameter int COUNT_WIDTH    = ddo_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = ddo_pkg::POSITION_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = ddo_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // wheel position input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddo_pkg::ddo_in_t                in_data,
  // pose output
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddo_pkg::ddo_out_t               out_data
);
  import ddo_pkg::*;

  // command word from the sequencer to the datapath
  ddo_cmd_t cmd;

  // sequencer: accept, scale, heading, cordic steps, pose multiply, accumulate, hand over
  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: registers, multipliers, cordic unit and the output register
  ddo_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH),
    .ANGLE_WIDTH    (ANGLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

  // an accepted transfer makes the block busy on the next cycle
  `DDO_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "not busy after input transfer")
  // at most one datapath operation per cycle
  `DDO_ASSERT_NOW(a_cmd_onehot, 1'b1,
    $onehot0({cmd.take, cmd.scale, cmd.diff, cmd.head, cmd.init, cmd.iter, cmd.round,
              cmd.mlo, cmd.mhi, cmd.acc, cmd.push}),
    "overlapping datapath commands")
  // the output register is only loaded when its previous result has gone
  `DDO_ASSERT_NOW(a_push_free, cmd.push, !out_valid || !out_stall, "result overwritten before transfer")
  // a loaded result is offered on the next cycle
  `DDO_ASSERT_NEXT(a_push_valid, cmd.push, out_valid, "loaded result not offered")

endmodule
